### rtl/core/gaussian_blur_5x5_clamped_assert.svh
// assertion macros used by the checker file of the 5x5 blur
// depends on nothing; included by name where assertions are written
`ifndef GAUSSIAN_BLUR_5X5_CLAMPED_ASSERT_SVH
`define GAUSSIAN_BLUR_5X5_CLAMPED_ASSERT_SVH

// same-cycle implication
`define GB5_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gb5 assertion failed");

// next-cycle implication
`define GB5_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gb5 assertion failed");

`endif

### rtl/core/gb5_pkg.sv
// shared types, constants and tap-sum functions of the 5x5 blur
// no dependencies
package gb5_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WCFG_W     = 11;
    localparam int HCFG_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int TAPS       = 5;
    localparam int LINES      = 4;
    localparam int LANE_W     = 2;
    localparam int PIX_W      = 8;
    localparam int VSUM_W     = 12;
    localparam int HSUM_W     = 16;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [TAPS-1:0] t_col;
    typedef logic [TAPS-1:0][VSUM_W-1:0] t_vsums;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic eol;
        logic eof;
        logic lor;
    } t_mark;

    // weights 1,4,6,4,1 over one column
    function automatic logic [VSUM_W-1:0] vsum(t_col p);
        return VSUM_W'(p[0]) + VSUM_W'(p[4])
             + (VSUM_W'(p[1]) << 2) + (VSUM_W'(p[3]) << 2)
             + (VSUM_W'(p[2]) << 2) + (VSUM_W'(p[2]) << 1);
    endfunction

    // weights 1,4,6,4,1 over the column sums
    function automatic logic [HSUM_W-1:0] hsum(t_vsums v);
        return HSUM_W'(v[0]) + HSUM_W'(v[4])
             + (HSUM_W'(v[1]) << 2) + (HSUM_W'(v[3]) << 2)
             + (HSUM_W'(v[2]) << 2) + (HSUM_W'(v[2]) << 1);
    endfunction

endpackage

### rtl/core/gb5_line_ram.sv
// line store: four rows side by side in one word per column, read-first
// depends on gb5_pkg
module gb5_line_ram import gb5_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [COL_W-1:0]         i_addr,
    input  logic [LANE_W-1:0]        i_lane,
    input  t_pix                     i_wdata,
    output logic [LINES*PIX_W-1:0]   o_rdata
);

    logic [LINES*PIX_W-1:0] r_mem [MAX_WIDTH];

    // old word comes out, one lane takes the new pixel
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rdata <= r_mem[i_addr];
            r_mem[i_addr][{i_lane, 3'b000} +: PIX_W] <= i_wdata;
        end
    end

endmodule

### rtl/core/gb5_col_cell.sv
// one column of the 5x5 window, handed to the left neighbor on shift
// depends on gb5_pkg
module gb5_col_cell import gb5_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  t_col i_col,
    output t_col o_col
);

    t_col r_col;

    // column register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

### rtl/core/gaussian_blur_5x5_clamped.sv
// top level of the 5x5 binomial blur with replicated borders
// depends on gb5_pkg, gb5_line_ram, gb5_col_cell
//
// One pixel per clock enters in raster order when not held. The line store
// is one 1024 x 32 read-first RAM (four rows per word); the window is a
// chain of five column cells that shifts once per input transaction. Most
// inputs cause one output and flow at one per cycle when not stalled; an
// input that closes the last column or the last row causes up to 3 (or 9
// at the frame corner) outputs, which leave one per cycle from the emission
// unit when not stalled, and input is held for those extra cycles. Width and
// height must be written only while idle (not enforced) and restart the frame.
module gaussian_blur_5x5_clamped import gb5_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] pixel_in
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [7:0] pixel_out
    output logic [1:0]            o_m_tuser,   // [0] end_of_line, [1] end_of_frame
    output logic                  o_m_tlast    // last_of_run
);

    logic [WCFG_W-1:0] r_w;
    logic [HCFG_W-1:0] r_h;
    logic [WCFG_W-1:0] w1;
    logic [HCFG_W-1:0] h1;
    logic [COL_W-1:0]  r_in_x;
    logic [ROW_W-1:0]  r_in_y;
    logic              s_acc;
    logic              last_col, last_row, has_r, has_c;
    logic [ROW_W-1:0]  rlo, rhi;
    logic [COL_W-1:0]  clo, chi;

    // stage 1: accepted pixel, waiting for line store data
    logic              r1_v;
    t_pix              r1_pix;
    logic [ROW_W-1:0]  r1_y;
    logic [ROW_W-1:0]  r1_rlo, r1_rhi;
    logic [COL_W-1:0]  r1_x, r1_clo, r1_chi;
    logic              r1_has;
    logic [LINES*PIX_W-1:0] rd;

    // stage 2: window and emission unit
    logic              r2_v;
    logic [ROW_W-1:0]  r2_r, r2_rhi, r2_y;
    logic [COL_W-1:0]  r2_c, r2_clo, r2_chi, r2_x;
    logic              g_last, emit, ready1, ready2, ready3, ready4, ready_o, mv12;
    t_col              new_col;
    t_col              win [TAPS];
    logic [2:0]        ksel [TAPS];
    logic [2:0]        jsel [TAPS];
    t_col              sel [TAPS];
    t_mark             mark;

    // stages 3, 4 and output
    logic              r3_v, r4_v, r_o_v;
    t_col              r3_p [TAPS];
    t_mark             r3_mark, r4_mark, r_o_mark;
    t_vsums            r4_s;
    logic [HSUM_W-1:0] total;
    t_pix              r_o_pix;

    assign w1 = r_w - WCFG_W'(1);
    assign h1 = r_h - HCFG_W'(1);
    assign s_acc = i_s_tvalid && o_s_tready;

    // config registers, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WCFG_W'(640);
            r_h <= HCFG_W'(480);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_WIDTH: begin
                    if (i_cfg_data[WCFG_W-1:0] == '0) begin
                        r_w <= WCFG_W'(1);
                    end else if (i_cfg_data[WCFG_W-1:0] > WCFG_W'(MAX_WIDTH)) begin
                        r_w <= WCFG_W'(MAX_WIDTH);
                    end else begin
                        r_w <= i_cfg_data[WCFG_W-1:0];
                    end
                end
                CFG_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        r_h <= HCFG_W'(1);
                    end else if (i_cfg_data > HCFG_W'(MAX_HEIGHT)) begin
                        r_h <= HCFG_W'(MAX_HEIGHT);
                    end else begin
                        r_h <= i_cfg_data;
                    end
                end
                default: begin
                    r_w <= r_w;
                end
            endcase
        end
    end

    // outputs caused by the current input position
    always_comb begin
        last_col = ({1'b0, r_in_x} == w1);
        last_row = ({1'b0, r_in_y} == h1);
        has_r = 1'b1;
        rlo = r_in_y - ROW_W'(2);
        rhi = rlo;
        if (last_row) begin
            rhi = h1[ROW_W-1:0];
            rlo = (h1 >= HCFG_W'(2)) ? h1[ROW_W-1:0] - ROW_W'(2) : '0;
        end else if (r_in_y < ROW_W'(2)) begin
            has_r = 1'b0;
        end
        has_c = 1'b1;
        clo = r_in_x - COL_W'(2);
        chi = clo;
        if (last_col) begin
            chi = w1[COL_W-1:0];
            clo = (w1 >= WCFG_W'(2)) ? w1[COL_W-1:0] - COL_W'(2) : '0;
        end else if (r_in_x < COL_W'(2)) begin
            has_c = 1'b0;
        end
    end

    // input position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_in_x <= '0;
            r_in_y <= '0;
        end else if (s_acc) begin
            if (last_col) begin
                r_in_x <= '0;
                r_in_y <= last_row ? '0 : r_in_y + ROW_W'(1);
            end else begin
                r_in_x <= r_in_x + COL_W'(1);
            end
        end
    end

    gb5_line_ram u_ram (
        .i_clk   (i_clk),
        .i_en    (s_acc),
        .i_addr  (r_in_x),
        .i_lane  (r_in_y[LANE_W-1:0]),
        .i_wdata (i_s_tdata),
        .o_rdata (rd)
    );

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (s_acc) begin
            r1_v <= 1'b1;
        end else if (mv12) begin
            r1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r1_pix <= i_s_tdata;
            r1_x   <= r_in_x;
            r1_y   <= r_in_y;
            r1_rlo <= rlo;
            r1_rhi <= rhi;
            r1_clo <= clo;
            r1_chi <= chi;
            r1_has <= has_r && has_c;
        end
    end

    // handshake chain
    assign ready_o    = !r_o_v || i_m_tready;
    assign ready4     = !r4_v || ready_o;
    assign ready3     = !r3_v || ready4;
    assign g_last     = (r2_r == r2_rhi) && (r2_c == r2_chi);
    assign emit       = r2_v && ready3;
    assign ready2     = !r2_v || (ready3 && g_last);
    assign mv12       = r1_v && ready2;
    assign ready1     = !r1_v || ready2;
    assign o_s_tready = ready1;

    // new window column: stored rows oldest first, then the pixel itself
    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            new_col[k] = rd[{LANE_W'(r1_y[LANE_W-1:0] + LANE_W'(k)), 3'b000} +: PIX_W];
        end
        new_col[TAPS-1] = r1_pix;
    end

    // chain of column cells, newest at the right end
    for (genvar j = 0; j < TAPS; j++) begin : g_cell
        gb5_col_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (mv12),
            .i_col   ((j == TAPS - 1) ? new_col : win[(j == TAPS - 1) ? j : j + 1]),
            .o_col   (win[j])
        );
    end

    // emission unit walks the columns of each row, row by row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r2_v <= 1'b0;
        end else if (mv12) begin
            r2_v <= r1_has;
        end else if (emit && g_last) begin
            r2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv12) begin
            r2_r   <= r1_rlo;
            r2_rhi <= r1_rhi;
            r2_c   <= r1_clo;
            r2_clo <= r1_clo;
            r2_chi <= r1_chi;
            r2_x   <= r1_x;
            r2_y   <= r1_y;
        end else if (emit && !g_last) begin
            if (r2_c == r2_chi) begin
                r2_c <= r2_clo;
                r2_r <= r2_r + ROW_W'(1);
            end else begin
                r2_c <= r2_c + COL_W'(1);
            end
        end
    end

    // clamped window indexes for the current output
    always_comb begin
        logic signed [ROW_W+1:0] rr;
        logic signed [COL_W+1:0] cc;
        for (int d = 0; d < TAPS; d++) begin
            rr = $signed({2'b00, r2_r}) + (ROW_W+2)'(d - 2);
            if (rr < 0) begin
                rr = '0;
            end
            if (rr > $signed({1'b0, h1})) begin
                rr = $signed({1'b0, h1});
            end
            rr = rr - $signed({2'b00, r2_y}) + (ROW_W+2)'(4);
            ksel[d] = rr[2:0];
            cc = $signed({2'b00, r2_c}) + (COL_W+2)'(d - 2);
            if (cc < 0) begin
                cc = '0;
            end
            if (cc > $signed({1'b0, w1})) begin
                cc = $signed({1'b0, w1});
            end
            cc = cc - $signed({2'b00, r2_x}) + (COL_W+2)'(4);
            jsel[d] = cc[2:0];
        end
        for (int dc = 0; dc < TAPS; dc++) begin
            for (int dr = 0; dr < TAPS; dr++) begin
                sel[dc][dr] = win[jsel[dc]][ksel[dr]];
            end
        end
        mark.eol = ({1'b0, r2_c} == w1);
        mark.eof = mark.eol && ({1'b0, r2_r} == h1);
        mark.lor = g_last;
    end

    // stage 3: selected neighborhood
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (ready3) begin
            r3_v <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r3_p    <= sel;
            r3_mark <= mark;
        end
    end

    // stage 4: column sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (ready4) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready4 && r3_v) begin
            for (int dc = 0; dc < TAPS; dc++) begin
                r4_s[dc] <= vsum(r3_p[dc]);
            end
            r4_mark <= r3_mark;
        end
    end

    // output register: row sum scaled by 1/256
    assign total = hsum(r4_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (ready_o) begin
            r_o_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_o && r4_v) begin
            r_o_pix  <= total[HSUM_W-1 -: PIX_W];
            r_o_mark <= r4_mark;
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = r_o_pix;
    assign o_m_tuser  = {r_o_mark.eof, r_o_mark.eol};
    assign o_m_tlast  = r_o_mark.lor;

endmodule

### rtl/core/gb5_checker.sv
// port-level checker of the 5x5 blur and its bind to the top level
// depends on gaussian_blur_5x5_clamped_assert.svh and gb5_pkg
`include "gaussian_blur_5x5_clamped_assert.svh"

module gb5_checker import gb5_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_wr_en,
    input logic                  i_cfg_addr,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [7:0]            i_s_tdata,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [7:0]            o_m_tdata,
    input logic [1:0]            o_m_tuser,
    input logic                  o_m_tlast
);

    // a stalled result transaction keeps its pixel
    `GB5_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // the frame corner is also the end of its line
    `GB5_ASSERT_IMP(a_eof_eol, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1], o_m_tuser[0])

    // the frame corner is the last output of the final input
    `GB5_ASSERT_IMP(a_eof_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1], o_m_tlast)

endmodule

bind gaussian_blur_5x5_clamped gb5_checker u_gb5_checker (.*);
